/* rtl/core/slt_pkg.sv */
// shared types and constants for the sorted list table
// no dependencies
package slt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 4;
	localparam int ECNT_W   = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
		logic [ECNT_W-1:0] entry_count;
		logic [1:0]        status;
	} out_word_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

/* rtl/core/slt_cell.sv */
// one slot of the sorted table: holds a value, compares it against the key
// and shifts toward either neighbor; depends on slt_pkg
module slt_cell (
	input  logic                              clk,
	input  slt_pkg::cell_ctl_t                ctl,
	input  logic                              occupied,
	input  logic                              left_less,
	input  logic signed [slt_pkg::VAL_W-1:0]  left_entry,
	input  logic signed [slt_pkg::VAL_W-1:0]  right_entry,
	output logic signed [slt_pkg::VAL_W-1:0]  entry,
	output logic                              less,
	output logic                              eq,
	output logic                              boundary
);

	logic signed [slt_pkg::VAL_W-1:0] entry_q;

	assign entry    = entry_q;
	assign less     = occupied && (entry_q < ctl.value);
	assign eq       = occupied && (entry_q == ctl.value);
	// first cell whose value is not smaller than the key
	assign boundary = !less && left_less;

	always_ff @(posedge clk) begin
		if (ctl.ins && !less) begin
			entry_q <= left_less ? ctl.value : left_entry;
		end else if (ctl.rem && !less) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* rtl/core/sorted_list_table_top.sv */
// top level of the sorted list table: chain of slt_cell slots, fill count
// and output register; depends on slt_pkg and slt_cell
//
//  channel | signals                   | word
//  --------+---------------------------+-------------------------------
//  in      | in_valid, in_ready        | in_data  (func, value)
//  out     | out_valid, out_ready      | out_data (found, position,
//          |                           |           entry_count, status)
//
// one word per cycle: every cell compares the key in parallel and the whole
// row shifts in the cycle the word is accepted; the result shows in the next
// cycle from the output register. in_ready is low only while a result is held
// and out_ready is low. reset empties the table by clearing the fill count.
module sorted_list_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  slt_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output slt_pkg::out_word_t  out_data
);

	localparam int N = slt_pkg::CAPACITY;

	logic [slt_pkg::CNT_W-1:0]          count_q;
	logic                               out_valid_q;
	slt_pkg::out_word_t                 out_q;
	slt_pkg::cell_ctl_t                 ctl;
	logic                               accept;
	logic                               full;
	logic                               found_any;
	logic [slt_pkg::IDX_W-1:0]          pos;
	logic signed [slt_pkg::VAL_W-1:0]   entry_w [N];
	logic [N-1:0]                       less_w;
	logic [N-1:0]                       eq_w;
	logic [N-1:0]                       bnd_w;
	slt_pkg::out_word_t                 res;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = (count_q == slt_pkg::CNT_W'(N));
	assign found_any = |eq_w;

	assign ctl.value = in_data.value;
	assign ctl.ins   = accept && (in_data.func == slt_pkg::OP_INSERT) && !full;
	assign ctl.rem   = accept && (in_data.func == slt_pkg::OP_REMOVE) && found_any;

	for (genvar i = 0; i < N; i++) begin : g_cell
		slt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (slt_pkg::CNT_W'(i) < count_q),
			.left_less   ((i == 0) ? 1'b1 : less_w[(i == 0) ? 0 : i-1]),
			.left_entry  (entry_w[(i == 0) ? 0 : i-1]),
			.right_entry (entry_w[(i == N-1) ? i : i+1]),
			.entry       (entry_w[i]),
			.less        (less_w[i]),
			.eq          (eq_w[i]),
			.boundary    (bnd_w[i])
		);
	end

	// boundary is one-hot or empty, so an or-reduce encodes it
	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			if (bnd_w[i]) begin
				pos = pos | slt_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		res = '0;
		res.entry_count = slt_pkg::ECNT_W'(count_q);
		case (slt_pkg::op_t'(in_data.func))
			slt_pkg::OP_INSERT: begin
				if (full) begin
					res.status = slt_pkg::ST_FULL;
				end else begin
					res.position    = slt_pkg::POS_W'(pos);
					res.entry_count = slt_pkg::ECNT_W'(count_q + 1'b1);
				end
			end
			slt_pkg::OP_SEARCH, slt_pkg::OP_REMOVE: begin
				if (found_any) begin
					res.found    = 1'b1;
					res.position = slt_pkg::POS_W'(pos);
					if (in_data.func == slt_pkg::OP_REMOVE) begin
						res.entry_count = slt_pkg::ECNT_W'(count_q - 1'b1);
					end
				end else begin
					res.status = slt_pkg::ST_MISSING;
				end
			end
			default: begin
				res.status = slt_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.rem) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slt_pkg::CNT_W'(N))
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == slt_pkg::ST_FULL
		|-> out_q.entry_count == slt_pkg::ECNT_W'(N))
		else $error("full status with free slots");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.found |-> out_q.status == slt_pkg::ST_OK)
		else $error("match reported with error status");
`endif

endmodule
